[hw/rtl/ordered_list_engine_assert.svh]
// assertion macros for the ordered list engine
// depends on nothing; included by the top level
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define OLE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OLE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define OLE_ASSERT(label, clk, rst_n, prop, msg)
`define OLE_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[hw/rtl/ole_pkg.sv]
// types and constants shared by the ordered list engine
// no dependencies
`default_nettype none
package ole_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned IdxW = $clog2(Capacity);

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_INSERT     = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_NONE       = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [6:0]         position;
  } req_t;

  typedef struct packed {
    logic               error;
    logic signed [31:0] removed_value;
    logic [6:0]         count;
  } rsp_t;

  // classified command handed from front to back
  typedef enum logic [3:0] {
    K_INS = 4'b0001,
    K_DEL = 4'b0010,
    K_CLR = 4'b0100,
    K_ERR = 4'b1000
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [CntW-1:0]    at;
    logic signed [31:0] value;
  } cmd_t;
endpackage
`default_nettype wire

[hw/rtl/ole_front.sv]
// front end: keeps a shadow length, checks each request, emits commands
// depends on ole_pkg
`default_nettype none
module ole_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ole_pkg::req_t  req_i,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  output ole_pkg::cmd_t       cmd_o,
  output logic                cmd_valid_o,
  input  wire logic           cmd_ready_i
);
  import ole_pkg::*;

  logic [CntW-1:0] len_q, len_d;
  logic [CntW-1:0] pos;
  logic            full, empty;
  cmd_t            cmd;

  assign pos   = CntW'(req_i.position);
  assign full  = (len_q >= CntW'(Capacity));
  assign empty = (len_q == '0);
  assign req_ready_o = cmd_ready_i;
  assign cmd_valid_o = req_valid_i;
  assign cmd_o = cmd;

  // classify request against the length it will see
  always_comb begin
    cmd.kind  = K_ERR;
    cmd.at    = '0;
    cmd.value = req_i.value;
    len_d     = len_q;
    case (op_e'(req_i.op))
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        if (op_e'(req_i.op) == OP_PUSH_BACK) cmd.at = len_q;
        else if (op_e'(req_i.op) == OP_INSERT) cmd.at = pos;
        if (!full && !(op_e'(req_i.op) == OP_INSERT && pos > len_q)) begin
          cmd.kind = K_INS;
          len_d    = len_q + 1'b1;
        end
      end
      OP_POP_BACK, OP_POP_FRONT, OP_REMOVE: begin
        if (op_e'(req_i.op) == OP_POP_BACK) cmd.at = len_q - 1'b1;
        else if (op_e'(req_i.op) == OP_REMOVE) cmd.at = pos;
        if (!empty && !(op_e'(req_i.op) == OP_REMOVE && pos >= len_q)) begin
          cmd.kind = K_DEL;
          len_d    = len_q - 1'b1;
        end
      end
      OP_CLEAR: begin
        cmd.kind = K_CLR;
        len_d    = '0;
      end
      default: cmd.kind = K_ERR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (req_valid_i && cmd_ready_i) begin
      len_q <= len_d;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/ole_fifo.sv]
// two-entry command queue between front and back
// depends on ole_pkg
`default_nettype none
module ole_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ole_pkg::cmd_t wr_data_i,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  output ole_pkg::cmd_t      rd_data_o,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i
);
  import ole_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  // pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

[hw/rtl/ole_back.sv]
// back end: row of cells that shift as one, plus the result register
// depends on ole_pkg
`default_nettype none
module ole_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ole_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  output ole_pkg::rsp_t      rsp_o,
  output logic               empty_o,
  input  wire logic          pop_i
);
  import ole_pkg::*;

  logic signed [31:0] cell_q [Capacity];
  logic [CntW-1:0]    len_q, len_d;
  logic               rv_q;
  rsp_t               rsp_q, rsp_d;
  logic               go;
  logic [IdxW-1:0]    at_idx;

  assign cmd_ready_o = !rv_q || pop_i;
  assign go      = cmd_valid_i && cmd_ready_o;
  assign empty_o = !rv_q;
  assign rsp_o   = rsp_q;
  assign at_idx  = cmd_i.at[IdxW-1:0];

  // result and length
  always_comb begin
    len_d = len_q;
    rsp_d.error = 1'b0;
    rsp_d.removed_value = '0;
    case (cmd_i.kind)
      K_INS: len_d = len_q + 1'b1;
      K_DEL: begin
        len_d = len_q - 1'b1;
        rsp_d.removed_value = cell_q[at_idx];
      end
      K_CLR: len_d = '0;
      default: rsp_d.error = 1'b1;
    endcase
    rsp_d.count = 7'(len_d);
  end

  // each cell loads from its neighbor, the new word, or holds
  always_ff @(posedge clk_i) begin
    if (go) begin
      for (int k = 0; k < Capacity; k++) begin
        if (cmd_i.kind == K_INS) begin
          if (CntW'(k) == cmd_i.at) cell_q[k] <= cmd_i.value;
          else if (CntW'(k) > cmd_i.at && k > 0) cell_q[k] <= cell_q[k-1];
        end else if (cmd_i.kind == K_DEL) begin
          if (CntW'(k) >= cmd_i.at && k < Capacity - 1) cell_q[k] <= cell_q[k+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      if (go) len_q <= len_d;
      if (go) rv_q <= 1'b1;
      else if (pop_i) rv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) rsp_q <= rsp_d;
  end
endmodule
`default_nettype wire

[hw/rtl/ordered_list_engine.sv]
// Ordered list engine: a double-ended list of up to 64 signed 32-bit words with
// positional insert and remove. Each request yields one result word. Requests
// are accepted one per cycle while the queue has room; the front checks the
// request against its own copy of the length, a two-entry queue buffers
// commands, and the back shifts the whole cell row by one place at once. The
// command is registered in the queue and then in the result register before
// the result is on the result ports, and throughput is one per cycle while
// results are popped. No clearing pass is needed after reset.
`default_nettype none
`include "ordered_list_engine_assert.svh"
module ordered_list_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ole_pkg::req_t req_i,
  input  wire logic          push,
  output logic               full,
  output ole_pkg::rsp_t      rsp_o,
  output logic               empty,
  input  wire logic          pop
);
  import ole_pkg::*;

  cmd_t f_cmd, b_cmd;
  logic f_valid, f_ready, b_valid, b_ready, req_ready;

  ole_front u_front (
    .clk_i, .rst_ni, .req_i, .req_valid_i(push), .req_ready_o(req_ready),
    .cmd_o(f_cmd), .cmd_valid_o(f_valid), .cmd_ready_i(f_ready)
  );

  ole_fifo u_fifo (
    .clk_i, .rst_ni, .wr_data_i(f_cmd), .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .rd_data_o(b_cmd), .rd_valid_o(b_valid), .rd_ready_i(b_ready)
  );

  ole_back u_back (
    .clk_i, .rst_ni, .cmd_i(b_cmd), .cmd_valid_i(b_valid), .cmd_ready_o(b_ready),
    .rsp_o, .empty_o(empty), .pop_i(pop)
  );

  assign full = !req_ready;

  // checks
  `OLE_ASSERT(a_count_range, clk_i, rst_ni, (empty || rsp_o.count <= 7'(Capacity)), "count too large")
  `OLE_ASSERT(a_err_no_value, clk_i, rst_ni, (empty || !rsp_o.error || rsp_o.removed_value == 0), "error with value")
  `OLE_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop |=> !empty && $stable(rsp_o)), "result lost")
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// testbench for the ordered list engine: drives request words through the
// push/full side and checks every response word against a behavioral list model
// depends on ole_pkg and ordered_list_engine
`default_nettype none
module tb;
  import ole_pkg::*;

  localparam int unsigned LimitCycles = 200000;

  // dut interface
  logic  clk_i;
  logic  rst_ni;
  req_t  req_i;
  logic  push;
  logic  full;
  rsp_t  rsp_o;
  logic  empty;
  logic  pop;

  ordered_list_engine u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .push  (push),
    .full  (full),
    .rsp_o (rsp_o),
    .empty (empty),
    .pop   (pop)
  );

  // directed row: request plus optional typed-in response
  typedef struct {
    req_t req;
    bit   has_rsp;
    rsp_t rsp;
  } dir_row_t;

  // list model state
  logic signed [31:0] list_q[$];
  rsp_t               pending_rsp[$];
  int                 mismatches;
  int                 cycle_cnt;
  bit                 drain_mode;
  bit                 no_stall;

  // clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // apply one request to the list model and return the response word
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int   at;
    int   n;
    o = '0;
    n = list_q.size();
    case (op_e'(r.op))
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        at = (r.op == OP_PUSH_BACK) ? n : (r.op == OP_PUSH_FRONT) ? 0 : int'(r.position);
        if (at > n || n >= Capacity) o.error = 1'b1;
        else list_q.insert(at, r.value);
      end
      OP_POP_BACK, OP_POP_FRONT, OP_REMOVE: begin
        at = (r.op == OP_POP_BACK) ? n - 1 : (r.op == OP_POP_FRONT) ? 0 : int'(r.position);
        if (n == 0 || at >= n) o.error = 1'b1;
        else begin
          o.removed_value = list_q[at];
          list_q.delete(at);
        end
      end
      OP_CLEAR: list_q.delete();
      default: o.error = 1'b1;
    endcase
    o.count = 7'(list_q.size());
    return o;
  endfunction

  // send one word; waits for acceptance, with random gaps before it
  task automatic send_word(req_t r, bit has_rsp, rsp_t typed);
    rsp_t e;
    if (!no_stall && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    req_i <= r;
    push  <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    e = apply_request(r);
    if (has_rsp && e != typed) report_mismatch("typed row", 32'(e), 32'(typed));
    pending_rsp.push_back(e);
    @(negedge clk_i);
  endtask

  // response side: random pop stalls, compare against the oldest expectation
  initial begin
    rsp_t e;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!no_stall && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      if (rst_ni && !empty) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected word", 32'(rsp_o.count), 32'd0);
        end else begin
          e = pending_rsp.pop_front();
          if (rsp_o.error !== e.error)
            report_mismatch("error", 32'(rsp_o.error), 32'(e.error));
          if (rsp_o.removed_value !== e.removed_value)
            report_mismatch("removed_value", rsp_o.removed_value, e.removed_value);
          if (rsp_o.count !== e.count)
            report_mismatch("count", 32'(rsp_o.count), 32'(e.count));
        end
      end
    end
  end

  function automatic req_t mk(op_e op, logic signed [31:0] v, logic [6:0] p);
    req_t r;
    r.op = op;
    r.value = v;
    r.position = p;
    return r;
  endfunction

  function automatic rsp_t rs(logic e, logic signed [31:0] v, logic [6:0] c);
    rsp_t o;
    o.error = e;
    o.removed_value = v;
    o.count = c;
    return o;
  endfunction

  // random request, mostly well-formed for the current length
  function automatic req_t rand_request();
    int   n;
    int   sel;
    op_e  op;
    logic [6:0] p;
    n = list_q.size();
    sel = $urandom_range(0, 99);
    if (sel < 2) op = OP_CLEAR;
    else if (sel < 3) op = OP_NONE;
    else if (n < 16) op = op_e'($urandom_range(0, 2) + ($urandom_range(0, 3) == 0 ? 3 : 0));
    else if (n > 56) op = op_e'($urandom_range(0, 5) % 3 + ($urandom_range(0, 3) ? 3 : 0));
    else op = op_e'($urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0) p = 7'($urandom_range(0, 127));
    else p = 7'($urandom_range(0, n));
    return mk(op, $urandom, p);
  endfunction

  // main stimulus
  initial begin
    dir_row_t rows[$];
    int       i;
    mismatches = 0;
    no_stall = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    req_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table: empty errors, extremes, positional cases, unused op
    rows.push_back('{mk(OP_POP_BACK, 0, 0), 1, rs(1, 0, 0)});
    rows.push_back('{mk(OP_POP_FRONT, 0, 0), 1, rs(1, 0, 0)});
    rows.push_back('{mk(OP_REMOVE, 0, 0), 1, rs(1, 0, 0)});
    rows.push_back('{mk(OP_INSERT, 5, 1), 1, rs(1, 0, 0)});
    rows.push_back('{mk(OP_PUSH_BACK, 32'sh7fffffff, 0), 1, rs(0, 0, 1)});
    rows.push_back('{mk(OP_PUSH_FRONT, 32'sh80000000, 0), 1, rs(0, 0, 2)});
    rows.push_back('{mk(OP_INSERT, -1, 2), 1, rs(0, 0, 3)});
    rows.push_back('{mk(OP_INSERT, 32'sh5a5a5a5a, 1), 0, '0});
    rows.push_back('{mk(OP_REMOVE, 0, 7'd127), 1, rs(1, 0, 4)});
    rows.push_back('{mk(OP_REMOVE, 0, 4), 1, rs(1, 0, 4)});
    rows.push_back('{mk(OP_NONE, -1, 7'd127), 1, rs(1, 0, 4)});
    rows.push_back('{mk(OP_REMOVE, 0, 1), 0, '0});
    rows.push_back('{mk(OP_POP_BACK, 0, 0), 1, rs(0, -1, 2)});
    rows.push_back('{mk(OP_POP_FRONT, 0, 0), 1, rs(0, 32'sh80000000, 1)});
    rows.push_back('{mk(OP_CLEAR, 0, 0), 1, rs(0, 0, 0)});
    rows.push_back('{mk(OP_CLEAR, 0, 0), 1, rs(0, 0, 0)});
    foreach (rows[k]) send_word(rows[k].req, rows[k].has_rsp, rows[k].rsp);

    // fill to capacity, then overflow on every insert form
    for (i = 0; i < Capacity; i++) send_word(mk(OP_PUSH_FRONT, $urandom, 0), 0, '0);
    send_word(mk(OP_PUSH_BACK, 1, 0), 1, rs(1, 0, 7'(Capacity)));
    send_word(mk(OP_PUSH_FRONT, 1, 0), 1, rs(1, 0, 7'(Capacity)));
    send_word(mk(OP_INSERT, 1, 7'(Capacity)), 1, rs(1, 0, 7'(Capacity)));
    send_word(mk(OP_REMOVE, 0, 7'(Capacity - 1)), 0, '0);
    send_word(mk(OP_INSERT, 7, 7'(Capacity - 1)), 0, '0);
    send_word(mk(OP_REMOVE, 0, 7'(Capacity)), 1, rs(1, 0, 7'(Capacity)));

    // hold off until the pipeline has drained
    push <= 1'b0;
    @(negedge clk_i);
    while (pending_rsp.size() != 0) @(negedge clk_i);

    // random part; the tail runs without idling
    for (i = 0; i < 1800; i++) begin
      if (i == 1500) no_stall = 1'b1;
      send_word(rand_request(), 0, '0);
    end
    push <= 1'b0;

    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

[ordered_list_engine.f]
+incdir+hw/rtl
hw/rtl/ole_pkg.sv
hw/rtl/ole_front.sv
hw/rtl/ole_fifo.sv
hw/rtl/ole_back.sv
hw/rtl/ordered_list_engine.sv
tb/sv/tb.sv
